// ----- rtl/bvm_pkg.sv -----
// Shared types, register codes and constants for the battery voltage monitor.
package bvm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 20;
	localparam int COUNT_W    = 4;
	localparam int LOWCNT_W   = 9;
	localparam int LIMIT_W    = 8;
	localparam int PERIOD_W   = 20;
	localparam int ACCUM_W    = 21;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int TRIM_SHIFT = 3;

	localparam logic [COUNT_W-1:0] WINDOW_LEN = 4'd10;

	localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST   = 16'd610;
	localparam logic [LIMIT_W-1:0]  LOW_COUNT_LIMIT_RST = 8'd5;
	localparam logic [PERIOD_W-1:0] ALERT_PERIOD_RST    = 20'd300000;
	localparam logic [PERIOD_W-1:0] CHECK_INTERVAL_RST  = 20'd30000;
	localparam logic [ACCUM_W-1:0]  ALERT_ACCUM_RST     = 21'd300000;

	// Register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_COUNT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALERT_PERIOD    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL  = 2'd3;

	// Battery status codes
	localparam logic [1:0] STATUS_FULL     = 2'd0;
	localparam logic [1:0] STATUS_LOW      = 2'd1;
	localparam logic [1:0] STATUS_SHUTDOWN = 2'd2;

	// Request function codes
	localparam logic FUNC_PERIODIC = 1'b0;
	localparam logic FUNC_STARTUP  = 1'b1;

	typedef struct packed {
		logic                func;
		logic [SAMPLE_W-1:0] sample;
	} smp_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [1:0]          status;
		logic                alert_tone;
		logic                shutdown_event;
		logic                from_startup;
	} res_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] low_threshold;
		logic [LIMIT_W-1:0]  low_count_limit;
		logic [PERIOD_W-1:0] alert_period;
		logic [PERIOD_W-1:0] check_interval;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  window_count;
		logic [SUM_W-1:0]    window_sum;
		logic [SAMPLE_W-1:0] window_max;
		logic [SAMPLE_W-1:0] window_min;
		logic [LOWCNT_W-1:0] low_count;
		logic [ACCUM_W-1:0]  alert_accum;
		logic [1:0]          battery_status;
	} state_t;

endpackage

// ----- rtl/battery_voltage_monitor_unit.sv -----
// Top level of the battery voltage monitor: request register, update logic, result register.
//
// Usage:
//   Sample channel (smp_valid / smp_stall / smp): each request carries func and an ADC
//   sample. func 0 adds the sample to the current window of ten; only the tenth sample
//   of a window gives a result. func 1 is a startup check that always gives a result.
//   Result channel (res_valid / res_stall / res): average, status, alert_tone,
//   shutdown_event and from_startup.
//   Config port (cfg_we / cfg_index / cfg_data): write low_threshold, low_count_limit,
//   alert_period and check_interval only while no request is in flight.
// Pipeline and throughput:
//   A request taken is held in the request register, runs through the combinational
//   update logic and its result is loaded into the result register. One request per
//   cycle is taken while smp_stall is low; smp_stall rises only when a result is stalled.
// Reset:
//   arst_n clears the window, low counter and status, sets the alert timer and the
//   registers to their defaults, and empties both the request and result registers.
// Stall:
//   While res_stall holds a result, the result register keeps it; a request that would
//   give a new result waits in the request register and smp_stall rises. Requests
//   that give no result keep flowing.
module battery_voltage_monitor_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 smp_valid,
	output logic                                 smp_stall,
	input  bvm_pkg::smp_t                        smp,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output bvm_pkg::res_t                        res,
	input  logic                                 cfg_we,
	input  logic [bvm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bvm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import bvm_pkg::*;

	cfg_t   cfg_q;
	state_t st_q;
	state_t st_nxt;
	smp_t   smp_s1;
	logic   valid_s1;
	res_t   res_q;
	logic   res_valid_q;
	res_t   res_nxt;
	logic   has_res;
	logic   out_free;
	logic   adv_s1;
	logic   accept;

	bvm_update u_update (
		.cfg     (cfg_q),
		.st      (st_q),
		.item    (smp_s1),
		.st_nxt  (st_nxt),
		.has_res (has_res),
		.res     (res_nxt)
	);

	// The result register can take a new result when empty or being drained
	assign out_free  = !res_valid_q || !res_stall;
	// Advance the held request unless its result has nowhere to go
	assign adv_s1    = valid_s1 && (out_free || !has_res);
	assign smp_stall = valid_s1 && !adv_s1;
	assign accept    = smp_valid && !smp_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_threshold   <= LOW_THRESHOLD_RST;
			cfg_q.low_count_limit <= LOW_COUNT_LIMIT_RST;
			cfg_q.alert_period    <= ALERT_PERIOD_RST;
			cfg_q.check_interval  <= CHECK_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOW_THRESHOLD:   cfg_q.low_threshold   <= cfg_data[SAMPLE_W-1:0];
				CFG_LOW_COUNT_LIMIT: cfg_q.low_count_limit <= cfg_data[LIMIT_W-1:0];
				CFG_ALERT_PERIOD:    cfg_q.alert_period    <= cfg_data[PERIOD_W-1:0];
				CFG_CHECK_INTERVAL:  cfg_q.check_interval  <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Monitor state: update once per advanced request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.window_count   <= '0;
			st_q.window_sum     <= '0;
			st_q.window_max     <= '0;
			st_q.window_min     <= '0;
			st_q.low_count      <= '0;
			st_q.alert_accum    <= ALERT_ACCUM_RST;
			st_q.battery_status <= STATUS_FULL;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	// Request register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Request payload: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1 <= smp;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && has_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/bvm_update.sv -----
// Next-state and result logic for one request of the battery voltage monitor.
module bvm_update (
	input  bvm_pkg::cfg_t   cfg,
	input  bvm_pkg::state_t st,
	input  bvm_pkg::smp_t   item,
	output bvm_pkg::state_t st_nxt,
	output logic            has_res,
	output bvm_pkg::res_t   res
);
	import bvm_pkg::*;

	logic [SUM_W-1:0]    sum_new;
	logic [SAMPLE_W-1:0] max_new;
	logic [SAMPLE_W-1:0] min_new;
	logic [COUNT_W-1:0]  count_inc;
	logic [SUM_W-1:0]    trimmed;
	logic [SAMPLE_W-1:0] avg;
	logic [LOWCNT_W-1:0] lc_new;
	logic [LIMIT_W:0]    limit_ext;

	always_comb begin
		if (st.window_count == '0) begin
			sum_new = {{(SUM_W-SAMPLE_W){1'b0}}, item.sample};
			max_new = item.sample;
			min_new = item.sample;
		end else begin
			sum_new = st.window_sum + {{(SUM_W-SAMPLE_W){1'b0}}, item.sample};
			max_new = (item.sample > st.window_max) ? item.sample : st.window_max;
			min_new = (item.sample < st.window_min) ? item.sample : st.window_min;
		end
		count_inc = st.window_count + 4'd1;
		trimmed   = sum_new - {{(SUM_W-SAMPLE_W){1'b0}}, max_new}
		                    - {{(SUM_W-SAMPLE_W){1'b0}}, min_new};
		avg       = trimmed[TRIM_SHIFT +: SAMPLE_W];
		limit_ext = {1'b0, cfg.low_count_limit};
		lc_new    = (st.low_count <= LOWCNT_W'(limit_ext)) ? st.low_count + 9'd1
		                                                   : st.low_count;
	end

	always_comb begin
		st_nxt  = st;
		has_res = 1'b0;
		res     = '0;
		if (item.func == FUNC_STARTUP) begin
			has_res = 1'b1;
			if (item.sample < cfg.low_threshold) begin
				st_nxt.battery_status = STATUS_SHUTDOWN;
				res.shutdown_event    = 1'b1;
			end
			res.average      = item.sample;
			res.status       = st_nxt.battery_status;
			res.from_startup = 1'b1;
		end else begin
			st_nxt.window_sum = sum_new;
			st_nxt.window_max = max_new;
			st_nxt.window_min = min_new;
			if (count_inc < WINDOW_LEN) begin
				st_nxt.window_count = count_inc;
			end else begin
				st_nxt.window_count = '0;
				has_res             = 1'b1;
				if (avg < cfg.low_threshold) begin
					st_nxt.low_count = lc_new;
					if (lc_new > LOWCNT_W'(limit_ext)) begin
						st_nxt.battery_status = STATUS_SHUTDOWN;
						res.shutdown_event    = 1'b1;
					end else begin
						if (st.battery_status == STATUS_FULL) begin
							st_nxt.battery_status = STATUS_LOW;
						end
						if (st.alert_accum > {1'b0, cfg.alert_period}) begin
							st_nxt.alert_accum = '0;
							res.alert_tone     = 1'b1;
						end else begin
							st_nxt.alert_accum = st.alert_accum + {1'b0, cfg.check_interval};
						end
					end
				end
				res.average = avg;
				res.status  = st_nxt.battery_status;
			end
		end
	end

endmodule

// ----- rtl/bvm_checker.sv -----
// Port-level assertions for the battery voltage monitor and their binding.
module bvm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_stall,
	input bvm_pkg::res_t res
);
	import bvm_pkg::*;

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// A shutdown event always reports shutdown status
	a_shut_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.shutdown_event |-> res.status == STATUS_SHUTDOWN)
		else $error("shutdown event without shutdown status");

	// An alert tone only comes from a low window result, never with shutdown
	a_tone_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.alert_tone |->
			!res.from_startup && !res.shutdown_event && res.status != STATUS_FULL)
		else $error("alert tone on an unexpected result");

	// Shutdown status is sticky across results
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && res.status == STATUS_SHUTDOWN ##1 res_valid
			|-> res.status == STATUS_SHUTDOWN)
		else $error("status left shutdown");

	// Status code never out of range
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status == STATUS_FULL || res.status == STATUS_LOW
			|| res.status == STATUS_SHUTDOWN)
		else $error("status code out of range");

endmodule

bind battery_voltage_monitor_unit bvm_checker u_bvm_checker (.*);

// ----- verif/tb_battery_voltage_monitor_unit.sv -----
// Self-checking testbench for the battery voltage monitor: predicts every report and compares it.
`timescale 1ns / 1ps

module tb_battery_voltage_monitor_unit;
	import bvm_pkg::*;

	localparam int LONG_HOLD_CYCLES  = 80;
	localparam int SETTLE_CYCLES     = 6;
	localparam int MAX_REPORTS_SHOWN = 10;
	localparam int RANDOM_PHASES     = 8;
	localparam int PHASE_ITEMS       = 80;
	localparam int STEADY_ITEMS      = 100;
	localparam longint RUN_LIMIT_NS  = 2_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  smp_valid = 1'b0;
	logic                  smp_stall;
	smp_t                  smp = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted monitor: register copies and running state
	logic [SAMPLE_W-1:0] thr_reg;
	logic [LIMIT_W-1:0]  limit_reg;
	logic [PERIOD_W-1:0] period_reg;
	logic [PERIOD_W-1:0] interval_reg;
	logic [COUNT_W-1:0]  win_cnt;
	logic [SUM_W-1:0]    win_sum;
	logic [SAMPLE_W-1:0] win_hi;
	logic [SAMPLE_W-1:0] win_lo;
	logic [LOWCNT_W-1:0] low_hits;
	logic [ACCUM_W-1:0]  tone_timer;
	logic [1:0]          batt_state;

	res_t pending_reports[$];
	res_t report_due;

	int  items_sent = 0;
	int  checked_reports = 0;
	int  startup_reports = 0;
	int  tone_reports = 0;
	int  shutdown_reports = 0;
	int  settings_applied = 0;
	int  input_backpressure_cycles = 0;
	int  mismatches = 0;
	int  hold_asked = 0;
	int  hold_given = 0;
	int  hold_left = 0;
	int  burst_left = 0;
	bit  tx_gaps_on = 1'b1;
	bit  rx_stalls_on = 1'b1;

	battery_voltage_monitor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Result side: short random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_asked != hold_given) begin
			hold_given <= hold_asked;
			hold_left  <= LONG_HOLD_CYCLES - 1;
			res_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left <= burst_left - 1;
			res_stall  <= 1'b1;
		end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
			burst_left <= $urandom_range(0, 3);
			res_stall  <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Compare every accepted report with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (smp_valid && smp_stall)
				input_backpressure_cycles++;
			if (res_valid && !res_stall) begin
				if (pending_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS_SHOWN)
						$display("%0t: unrequested report avg=%0d status=%0d tone=%b shut=%b boot=%b",
							$time, res.average, res.status, res.alert_tone,
							res.shutdown_event, res.from_startup);
				end else begin
					report_due = pending_reports.pop_front();
					checked_reports++;
					if (report_due.from_startup)   startup_reports++;
					if (report_due.alert_tone)     tone_reports++;
					if (report_due.shutdown_event) shutdown_reports++;
					if (res.average !== report_due.average ||
						res.status !== report_due.status ||
						res.alert_tone !== report_due.alert_tone ||
						res.shutdown_event !== report_due.shutdown_event ||
						res.from_startup !== report_due.from_startup) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS_SHOWN) begin
							$display("%0t: report %0d wanted avg=%0d status=%0d tone=%b shut=%b boot=%b",
								$time, checked_reports, report_due.average, report_due.status,
								report_due.alert_tone, report_due.shutdown_event,
								report_due.from_startup);
							$display("%0t: report %0d got    avg=%0d status=%0d tone=%b shut=%b boot=%b",
								$time, checked_reports, res.average, res.status, res.alert_tone,
								res.shutdown_event, res.from_startup);
						end
					end
				end
			end
		end
	end

	task automatic reset_prediction();
		thr_reg      = LOW_THRESHOLD_RST;
		limit_reg    = LOW_COUNT_LIMIT_RST;
		period_reg   = ALERT_PERIOD_RST;
		interval_reg = CHECK_INTERVAL_RST;
		win_cnt      = '0;
		win_sum      = '0;
		win_hi       = '0;
		win_lo       = '0;
		low_hits     = '0;
		tone_timer   = ALERT_ACCUM_RST;
		batt_state   = STATUS_FULL;
	endtask

	// Advance the predicted monitor by one request; queue the report it gives, if any
	task automatic predict_battery_result(input smp_t req);
		res_t                r;
		logic [SUM_W-1:0]    trimmed;
		r = '0;
		if (req.func == FUNC_STARTUP) begin
			if (req.sample < thr_reg) begin
				batt_state       = STATUS_SHUTDOWN;
				r.shutdown_event = 1'b1;
			end
			r.average      = req.sample;
			r.status       = batt_state;
			r.from_startup = 1'b1;
			pending_reports.push_back(r);
		end else begin
			if (win_cnt == '0) begin
				win_sum = SUM_W'(req.sample);
				win_hi  = req.sample;
				win_lo  = req.sample;
			end else begin
				win_sum = win_sum + SUM_W'(req.sample);
				if (req.sample > win_hi) win_hi = req.sample;
				if (req.sample < win_lo) win_lo = req.sample;
			end
			win_cnt = win_cnt + COUNT_W'(1);
			if (win_cnt == WINDOW_LEN) begin
				win_cnt   = '0;
				trimmed   = win_sum - SUM_W'(win_hi) - SUM_W'(win_lo);
				r.average = trimmed[TRIM_SHIFT +: SAMPLE_W];
				if (r.average < thr_reg) begin
					// the low counter stops one past the limit and never clears
					if (low_hits <= LOWCNT_W'(limit_reg))
						low_hits = low_hits + LOWCNT_W'(1);
					if (low_hits > LOWCNT_W'(limit_reg)) begin
						batt_state       = STATUS_SHUTDOWN;
						r.shutdown_event = 1'b1;
					end else begin
						if (batt_state < STATUS_LOW)
							batt_state = STATUS_LOW;
						if (tone_timer > ACCUM_W'(period_reg)) begin
							tone_timer   = '0;
							r.alert_tone = 1'b1;
						end else begin
							tone_timer = tone_timer + ACCUM_W'(interval_reg);
						end
					end
				end
				r.status = batt_state;
				pending_reports.push_back(r);
			end
		end
	endtask

	// Offer one request and hold it until it is taken
	task automatic offer_sample(input logic f, input logic [SAMPLE_W-1:0] s);
		smp_t item;
		item.func   = f;
		item.sample = s;
		if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
			smp_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		smp       <= item;
		smp_valid <= 1'b1;
		@(posedge clk);
		while (smp_stall) @(posedge clk);
		predict_battery_result(item);
		items_sent++;
	endtask

	// Drop valid, let every predicted report come back, then let the pipe empty
	task automatic wait_reports_drained();
		smp_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_LOW_THRESHOLD:   thr_reg      = val[SAMPLE_W-1:0];
			CFG_LOW_COUNT_LIMIT: limit_reg    = val[LIMIT_W-1:0];
			CFG_ALERT_PERIOD:    period_reg   = val[PERIOD_W-1:0];
			CFG_CHECK_INTERVAL:  interval_reg = val[PERIOD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_monitor(input logic [SAMPLE_W-1:0] thr, input logic [LIMIT_W-1:0] lim,
		input logic [PERIOD_W-1:0] per, input logic [PERIOD_W-1:0] ivl);
		put_register(CFG_LOW_THRESHOLD, CFG_DATA_W'(thr));
		put_register(CFG_LOW_COUNT_LIMIT, CFG_DATA_W'(lim));
		put_register(CFG_ALERT_PERIOD, per);
		put_register(CFG_CHECK_INTERVAL, ivl);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	function automatic logic [SAMPLE_W-1:0] clip16(input int v);
		if (v < 0) return '0;
		if (v > 65535) return 16'hFFFF;
		return v[SAMPLE_W-1:0];
	endfunction

	// Mostly hover around the threshold so both sides of the compare get hit
	function automatic int pick_level();
		int lv;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: lv = int'(thr_reg) + int'($urandom_range(0, 255)) - 128;
			6, 7:             lv = int'($urandom_range(0, 65535));
			8:                lv = int'($urandom_range(0, 2047));
			default:          lv = int'($urandom_range(60000, 65535));
		endcase
		return lv;
	endfunction

	function automatic logic [SAMPLE_W-1:0] window_sample(input int lv);
		// occasional outlier so the trim has something to remove
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return clip16(lv + int'($urandom_range(0, 32)) - 16);
	endfunction

	// Mostly complete windows at one level; some lone startup checks and ragged runs
	task automatic send_random_traffic(input int n);
		int stop_at;
		int kind;
		int lv;
		int fill;
		int k;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 19);
			if (kind < 15) begin
				lv   = pick_level();
				fill = int'(WINDOW_LEN) - int'(win_cnt);
				for (k = 0; k < fill; k++) begin
					if ($urandom_range(0, 14) == 0)
						offer_sample(FUNC_STARTUP, clip16(pick_level()));
					offer_sample(FUNC_PERIODIC, window_sample(lv));
				end
			end else if (kind < 18) begin
				offer_sample(FUNC_STARTUP, clip16(pick_level()));
			end else begin
				fill = $urandom_range(1, 9);
				for (k = 0; k < fill; k++)
					offer_sample(FUNC_PERIODIC, 16'($urandom_range(0, 65535)));
			end
		end
	endtask

	// Reset settings: a low window framed by both sample extremes, then a tone window
	task automatic test_directed_cases();
		int k;
		offer_sample(FUNC_PERIODIC, 16'hFFFF);
		offer_sample(FUNC_PERIODIC, 16'h0000);
		for (k = 0; k < 8; k++)
			offer_sample(FUNC_PERIODIC, 16'd100);
		// one under the threshold; the timer is now past the period
		for (k = 0; k < 10; k++)
			offer_sample(FUNC_PERIODIC, LOW_THRESHOLD_RST - 16'd1);
		// startup checks above and exactly at the threshold leave the status alone
		offer_sample(FUNC_STARTUP, 16'hFFFF);
		offer_sample(FUNC_STARTUP, LOW_THRESHOLD_RST);
	endtask

	// Every mean is low: run the counter past a small limit and keep going
	task automatic test_low_count_saturation();
		int k;
		wait_reports_drained();
		program_monitor(16'hFFFF, 8'd3, ALERT_PERIOD_RST, CHECK_INTERVAL_RST);
		for (k = 0; k < 40; k++)
			offer_sample(FUNC_PERIODIC, 16'($urandom_range(0, 65535)));
	endtask

	task automatic test_startup_shutdown();
		offer_sample(FUNC_STARTUP, 16'h0000);
		offer_sample(FUNC_STARTUP, 16'hFFFF);
	endtask

	task automatic test_random_settings();
		logic [SAMPLE_W-1:0] thr;
		logic [LIMIT_W-1:0]  lim;
		logic [PERIOD_W-1:0] per;
		logic [PERIOD_W-1:0] ivl;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			thr = 16'($urandom_range(100, 40000));
			lim = 8'($urandom_range(0, 255));
			per = 20'($urandom_range(0, 200000));
			ivl = 20'($urandom_range(0, 100000));
			case (phase)
				0: thr = 16'h0000;
				1: thr = 16'hFFFF;
				2: lim = 8'h00;
				3: lim = 8'hFF;
				4: begin
					per = 20'h00000;
					ivl = 20'hFFFFF;
				end
				5: per = 20'hFFFFF;
				6: ivl = 20'h00000;
				default: ;
			endcase
			wait_reports_drained();
			program_monitor(thr, lim, per, ivl);
			send_random_traffic(PHASE_ITEMS);
		end
	endtask

	// Hold the result side for a long stretch while requests keep coming back to back
	task automatic test_result_backpressure();
		int k;
		wait_reports_drained();
		program_monitor(16'd20000, 8'hFF, 20'd90000, 20'd30000);
		hold_asked++;
		do @(posedge clk); while (!res_stall);
		tx_gaps_on = 1'b0;
		for (k = 0; k < 12; k++)
			offer_sample(FUNC_STARTUP, 16'($urandom_range(0, 65535)));
		for (k = 0; k < 20; k++)
			offer_sample(FUNC_PERIODIC, window_sample(int'(thr_reg)));
		tx_gaps_on = 1'b1;
		wait_reports_drained();
	endtask

	// Close out with no idling on either side
	task automatic test_steady_stream();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		send_random_traffic(STEADY_ITEMS);
	endtask

	initial begin
		reset_prediction();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_low_count_saturation();
		test_startup_shutdown();
		test_random_settings();
		test_result_backpressure();
		test_steady_stream();
		wait_reports_drained();
		$display("Sent %0d samples over %0d register settings; checked %0d reports (%0d startup).",
			items_sent, settings_applied + 1, checked_reports, startup_reports);
		$display("Saw %0d alert tones, %0d shutdown events, %0d cycles of input held back.",
			tone_reports, shutdown_reports, input_backpressure_cycles);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Run stopped by timeout with %0d reports pending", pending_reports.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
